### hdl/stall_antijam_sequencer_assert.svh
// assertion macros for the stall anti-jam sequencer
`ifndef STALL_ANTIJAM_SEQUENCER_ASSERT_SVH
`define STALL_ANTIJAM_SEQUENCER_ASSERT_SVH
`ifndef ASSERT_OFF
`define SAS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sas assertion failed");
`define SAS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sas assertion failed");
`else
`define SAS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SAS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hdl/sas_pkg.sv
// types and constants of the stall anti-jam sequencer
package sas_pkg;

    typedef enum logic [1:0] {
        PH_STOPPED = 2'd0,
        PH_FORWARD = 2'd1,
        PH_REVERSE = 2'd2
    } t_phase;

    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_RUN  = 2'd1;
    localparam logic [1:0] MODE_STOP = 2'd2;

    localparam logic [2:0] CFG_SETTLE   = 3'd0;
    localparam logic [2:0] CFG_POLL     = 3'd1;
    localparam logic [2:0] CFG_LEVEL    = 3'd2;
    localparam logic [2:0] CFG_CONFIRM  = 3'd3;
    localparam logic [2:0] CFG_GIVEUP   = 3'd4;
    localparam logic [2:0] CFG_JAMCLEAR = 3'd5;
    localparam logic [2:0] CFG_BACKOFF  = 3'd6;
    localparam logic [2:0] CFG_HOLD     = 3'd7;

    typedef struct packed {
        logic [1:0] mode;
        logic       step_slot;
        logic [9:0] load_reading;
    } t_req;

    typedef struct packed {
        logic [1:0] phase;
        logic       driver_enable;
        logic       step_pulse;
        logic       step_backward;
        logic       stall_seen;
        logic       gave_up;
    } t_res;

endpackage

### hdl/stall_antijam_sequencer.sv
// stall anti-jam motor sequencer, top level
//
//  channel   | direction | handshake                     | payload
//  request   | in        | i_req_valid / o_req_stall     | i_req (mode, slot, load)
//  result    | out       | o_res_valid / i_res_stall     | o_res (phase, enable, step, flags)
//  config    | in        | i_cfg_valid / o_cfg_ready     | i_cfg_index, i_cfg_data
//
//  one request per cycle while o_req_stall is low; the state update is a single pass of counters
//  and compares between the accepted request and the result register
//  a skid stage behind the result register absorbs one result while the output stalls
//  reset (synchronous, active low) restores the default configuration and stopped state
//  config port is always ready; writes are meant to happen while the block is idle
`include "stall_antijam_sequencer_assert.svh"
module stall_antijam_sequencer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    output logic                o_req_stall,
    input  sas_pkg::t_req       i_req,
    output logic                o_res_valid,
    input  logic                i_res_stall,
    output sas_pkg::t_res       o_res,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    import sas_pkg::*;

    // configuration registers
    logic [15:0] r_settle, r_poll, r_giveup, r_jam_clear, r_backoff;
    logic [9:0]  r_level;
    logic [7:0]  r_confirm;
    logic        r_hold;

    // sequencer state
    t_phase      r_phase, n_phase;
    logic        r_enable, n_enable;
    logic        r_gave_up, n_gave_up;
    logic [16:0] r_fwd_elapsed, n_fwd_elapsed;
    logic [15:0] r_since_poll, n_since_poll;
    logic [7:0]  r_low_count, n_low_count;
    logic        r_jam_active, n_jam_active;
    logic [16:0] r_jam_elapsed, n_jam_elapsed;
    logic [15:0] r_backoff_left, n_backoff_left;

    // result register and skid stage
    logic        r_res_valid, r_skid_valid;
    t_res        r_res, r_skid;
    t_res        n_res;

    logic        req_acc, res_take;

    // timing helpers
    logic [16:0] fwd_inc, jam_inc, jam_at_stall;
    logic [15:0] poll_inc, back_dec;
    logic [7:0]  low_inc;
    logic        stall_hit;

    assign o_cfg_ready = 1'b1;
    assign o_req_stall = r_skid_valid;
    assign req_acc     = i_req_valid && !o_req_stall;
    assign res_take    = r_res_valid && !i_res_stall;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle    <= 16'd500;
            r_poll      <= 16'd20;
            r_level     <= 10'd50;
            r_confirm   <= 8'd3;
            r_giveup    <= 16'd5000;
            r_jam_clear <= 16'd2000;
            r_backoff   <= 16'd200;
            r_hold      <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SETTLE:   r_settle    <= i_cfg_data;
                CFG_POLL:     r_poll      <= i_cfg_data;
                CFG_LEVEL:    r_level     <= i_cfg_data[9:0];
                CFG_CONFIRM:  r_confirm   <= i_cfg_data[7:0];
                CFG_GIVEUP:   r_giveup    <= i_cfg_data;
                CFG_JAMCLEAR: r_jam_clear <= i_cfg_data;
                CFG_BACKOFF:  r_backoff   <= i_cfg_data;
                CFG_HOLD:     r_hold      <= i_cfg_data[0];
                default:      ;
            endcase
        end
    end

    // saturating time counters, advanced only by ticks
    assign fwd_inc  = (r_fwd_elapsed == '1) ? r_fwd_elapsed : r_fwd_elapsed + 17'd1;
    assign poll_inc = (r_since_poll == '1) ? r_since_poll : r_since_poll + 16'd1;
    assign jam_inc  = !r_jam_active ? r_jam_elapsed
                    : (r_jam_elapsed == '1) ? r_jam_elapsed : r_jam_elapsed + 17'd1;
    assign low_inc  = (r_low_count == '1) ? r_low_count : r_low_count + 8'd1;
    // a stall opens a fresh episode when none is running
    assign jam_at_stall = r_jam_active ? jam_inc : 17'd0;
    assign back_dec = r_backoff_left - 16'd1;

    // next state and result for the request at hand
    always_comb begin
        n_phase        = r_phase;
        n_enable       = r_enable;
        n_gave_up      = r_gave_up;
        n_fwd_elapsed  = r_fwd_elapsed;
        n_since_poll   = r_since_poll;
        n_low_count    = r_low_count;
        n_jam_active   = r_jam_active;
        n_jam_elapsed  = r_jam_elapsed;
        n_backoff_left = r_backoff_left;
        n_res          = '0;
        stall_hit      = 1'b0;

        unique case (i_req.mode)
            MODE_TICK: begin
                n_fwd_elapsed = fwd_inc;
                n_since_poll  = poll_inc;
                n_jam_elapsed = jam_inc;
                unique case (r_phase)
                    PH_FORWARD: begin
                        n_res.step_pulse = i_req.step_slot;
                        // stall check: settle window, then poll period, then level
                        priority if (fwd_inc < {1'b0, r_settle}) begin
                            n_low_count = '0;
                        end else if (poll_inc < r_poll) begin
                            n_low_count = r_low_count;
                        end else begin
                            n_since_poll = '0;
                            if (i_req.load_reading < r_level) begin
                                if (low_inc >= r_confirm) begin
                                    n_low_count = '0;
                                    stall_hit   = 1'b1;
                                end else begin
                                    n_low_count = low_inc;
                                end
                            end else begin
                                n_low_count = '0;
                            end
                        end
                        if (stall_hit) begin
                            n_res.stall_seen = 1'b1;
                            n_jam_active     = 1'b1;
                            n_jam_elapsed    = jam_at_stall;
                            if (jam_at_stall > {1'b0, r_giveup}) begin
                                // episode too long: stop and flag
                                n_gave_up = 1'b1;
                                n_phase   = PH_STOPPED;
                                if (!r_hold) begin
                                    n_enable = 1'b0;
                                end
                            end else begin
                                n_backoff_left = r_backoff;
                                n_phase        = PH_REVERSE;
                            end
                        end else if (r_jam_active && fwd_inc > {1'b0, r_jam_clear}) begin
                            n_jam_active  = 1'b0;
                            n_jam_elapsed = '0;
                        end
                    end
                    PH_REVERSE: begin
                        if (i_req.step_slot && r_backoff_left != '0) begin
                            n_res.step_pulse    = 1'b1;
                            n_res.step_backward = 1'b1;
                            n_backoff_left      = back_dec;
                        end
                        // back-off done: forward again in the same tick
                        if (n_backoff_left == '0) begin
                            n_phase       = PH_FORWARD;
                            n_fwd_elapsed = '0;
                        end
                    end
                    default: ;
                endcase
            end
            MODE_RUN: begin
                n_gave_up     = 1'b0;
                n_jam_active  = 1'b0;
                n_jam_elapsed = '0;
                n_enable      = 1'b1;
                n_phase       = PH_FORWARD;
                n_fwd_elapsed = '0;
            end
            MODE_STOP: begin
                n_phase = PH_STOPPED;
                if (!r_hold) begin
                    n_enable = 1'b0;
                end
            end
            default: ;   // unused mode leaves the state alone
        endcase

        n_res.phase         = n_phase;
        n_res.driver_enable = n_enable;
        n_res.gave_up       = n_gave_up;
    end

    // state update on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_STOPPED;
            r_enable       <= 1'b0;
            r_gave_up      <= 1'b0;
            r_fwd_elapsed  <= '0;
            r_since_poll   <= '1;
            r_low_count    <= '0;
            r_jam_active   <= 1'b0;
            r_jam_elapsed  <= '0;
            r_backoff_left <= '0;
        end else if (req_acc) begin
            r_phase        <= n_phase;
            r_enable       <= n_enable;
            r_gave_up      <= n_gave_up;
            r_fwd_elapsed  <= n_fwd_elapsed;
            r_since_poll   <= n_since_poll;
            r_low_count    <= n_low_count;
            r_jam_active   <= n_jam_active;
            r_jam_elapsed  <= n_jam_elapsed;
            r_backoff_left <= n_backoff_left;
        end
    end

    // result register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (res_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (req_acc) begin
            if (!r_res_valid || res_take) begin
                r_res_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (res_take) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (res_take) begin
                r_res <= r_skid;
            end
        end else if (req_acc) begin
            if (!r_res_valid || res_take) begin
                r_res <= n_res;
            end else begin
                r_skid <= n_res;
            end
        end
    end

    // checks
    `SAS_ASSERT_IMP(a_skid_behind_res, i_clk, i_rst_n, r_skid_valid, r_res_valid)
    `SAS_ASSERT_IMP(a_moving_enabled, i_clk, i_rst_n, r_phase != PH_STOPPED, r_enable)
    `SAS_ASSERT_IMP(a_gave_up_stopped, i_clk, i_rst_n, r_gave_up, r_phase == PH_STOPPED)
    `SAS_ASSERT_NXT(a_skid_drains, i_clk, i_rst_n, r_skid_valid && res_take, !r_skid_valid)

endmodule

### tb/sv/tb.sv
// self-checking testbench for the stall anti-jam sequencer
`timescale 1ns / 100ps

module tb;
    import sas_pkg::*;

    // mode code that the block ignores
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    t_req        req_data = '0;
    logic        res_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_index = CFG_SETTLE;
    logic [15:0] cfg_data = '0;

    logic        o_req_stall;
    logic        o_res_valid;
    t_res        o_res;
    logic        o_cfg_ready;

    stall_antijam_sequencer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (req_data),
        .o_res_valid (o_res_valid),
        .i_res_stall (res_stall),
        .o_res       (o_res),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // requests waiting to be sent, and the outputs they must produce
    t_req cmd_queue[$];
    t_res motor_outputs_due[$];

    // predicted configuration, reset values
    logic [15:0] settle_ms = 16'd500;
    logic [15:0] poll_gap_ms = 16'd20;
    logic [9:0]  low_level = 10'd50;
    logic [7:0]  confirm_need = 8'd3;
    logic [15:0] giveup_ms = 16'd5000;
    logic [15:0] jam_clear_after = 16'd2000;
    logic [15:0] backoff_len = 16'd200;
    logic        hold_idle = 1'b0;

    // predicted sequencer state, reset values
    t_phase      motor_phase = PH_STOPPED;
    logic        drv_en = 1'b0;
    logic        gave_up_flag = 1'b0;
    logic [16:0] fwd_ms = '0;
    logic [15:0] poll_ms = 16'hFFFF;
    logic [7:0]  low_run = '0;
    logic        jam_open = 1'b0;
    logic [16:0] jam_ms = '0;
    logic [15:0] steps_back_left = '0;

    int  mismatches = 0;
    int  sent_reqs = 0;
    int  checked_results = 0;
    int  settings_used = 0;
    int  stalls_due = 0;
    int  giveups_due = 0;
    int  back_steps_due = 0;
    int  cycles = 0;
    int  send_wait = 0;
    int  recv_wait = 0;
    bit  idle_on = 1'b0;

    function automatic int draw_wait();
        if (!idle_on || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    // stop: the driver drops unless it is held while idle
    function automatic void halt_motor();
        motor_phase = PH_STOPPED;
        if (!hold_idle)
            drv_en = 1'b0;
    endfunction

    // next state and outputs of the sequencer for one request
    function automatic t_res advance_sequencer(input t_req rq);
        t_res r;
        logic stall_hit;
        r = '0;
        stall_hit = 1'b0;
        case (rq.mode)
            MODE_TICK: begin
                // all time counters saturate
                if (fwd_ms != 17'h1FFFF) fwd_ms = fwd_ms + 17'd1;
                if (poll_ms != 16'hFFFF) poll_ms = poll_ms + 16'd1;
                if (jam_open && jam_ms != 17'h1FFFF) jam_ms = jam_ms + 17'd1;
                if (motor_phase == PH_FORWARD) begin
                    r.step_pulse = rq.step_slot;
                    if (fwd_ms < {1'b0, settle_ms}) begin
                        low_run = '0;
                    end else if (poll_ms >= poll_gap_ms) begin
                        poll_ms = '0;
                        if (rq.load_reading < low_level) begin
                            if (low_run != 8'hFF) low_run = low_run + 8'd1;
                            if (low_run >= confirm_need) begin
                                low_run = '0;
                                stall_hit = 1'b1;
                            end
                        end else begin
                            low_run = '0;
                        end
                    end
                    if (stall_hit) begin
                        r.stall_seen = 1'b1;
                        if (!jam_open) begin
                            jam_open = 1'b1;
                            jam_ms = '0;
                        end
                        if (jam_ms > {1'b0, giveup_ms}) begin
                            gave_up_flag = 1'b1;
                            halt_motor();
                        end else begin
                            steps_back_left = backoff_len;
                            motor_phase = PH_REVERSE;
                        end
                    end else if (jam_open && fwd_ms > {1'b0, jam_clear_after}) begin
                        jam_open = 1'b0;
                        jam_ms = '0;
                    end
                end else if (motor_phase == PH_REVERSE) begin
                    if (rq.step_slot && steps_back_left != 0) begin
                        r.step_pulse = 1'b1;
                        r.step_backward = 1'b1;
                        steps_back_left = steps_back_left - 16'd1;
                    end
                    // back-off done: forward again in the same tick
                    if (steps_back_left == 0) begin
                        motor_phase = PH_FORWARD;
                        fwd_ms = '0;
                    end
                end
            end
            MODE_RUN: begin
                gave_up_flag = 1'b0;
                jam_open = 1'b0;
                jam_ms = '0;
                drv_en = 1'b1;
                motor_phase = PH_FORWARD;
                fwd_ms = '0;
            end
            MODE_STOP: halt_motor();
            default: ;
        endcase
        r.phase = motor_phase;
        r.driver_enable = drv_en;
        r.gave_up = gave_up_flag;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic compare_field(input string name, input logic [1:0] got,
                                 input logic [1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d (result %0d)",
                                      name, got, want, checked_results));
    endtask

    // request driver: one new request per handshake, random gap after each
    always @(posedge clk) begin : drive_req
        t_res want;
        if (rst_n) begin
            if (req_valid && !o_req_stall) begin
                want = advance_sequencer(req_data);
                motor_outputs_due.push_back(want);
                sent_reqs++;
                stalls_due += want.stall_seen;
                back_steps_due += want.step_backward;
                if (want.stall_seen && want.gave_up) giveups_due++;
            end
            if (!req_valid || !o_req_stall) begin
                if (send_wait > 0) begin
                    send_wait--;
                    req_valid <= 1'b0;
                end else if (cmd_queue.size() != 0) begin
                    req_data <= cmd_queue.pop_front();
                    req_valid <= 1'b1;
                    send_wait = draw_wait();
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: checks every accepted result, stalls at random after each
    always @(posedge clk) begin : watch_res
        t_res want;
        if (rst_n) begin
            if (o_res_valid && !res_stall) begin
                checked_results++;
                if (motor_outputs_due.size() == 0) begin
                    report_mismatch($sformatf("result %h with nothing expected", o_res));
                end else begin
                    want = motor_outputs_due.pop_front();
                    compare_field("phase", o_res.phase, want.phase);
                    compare_field("driver_enable", o_res.driver_enable, want.driver_enable);
                    compare_field("step_pulse", o_res.step_pulse, want.step_pulse);
                    compare_field("step_backward", o_res.step_backward, want.step_backward);
                    compare_field("stall_seen", o_res.stall_seen, want.stall_seen);
                    compare_field("gave_up", o_res.gave_up, want.gave_up);
                end
                recv_wait = draw_wait();
            end
            if (recv_wait > 0) begin
                recv_wait--;
                res_stall <= 1'b1;
            end else begin
                res_stall <= 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("stall_antijam_sequencer verification failed");
            $finish;
        end
    end

    // wait at the falling edge until every request is out and every result back
    task automatic drain_block(input int extra);
        @(negedge clk);
        while (cmd_queue.size() != 0 || req_valid || motor_outputs_due.size() != 0)
            @(negedge clk);
        repeat (extra) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!o_cfg_ready);
        case (idx)
            CFG_SETTLE:   settle_ms = val;
            CFG_POLL:     poll_gap_ms = val;
            CFG_LEVEL:    low_level = val[9:0];
            CFG_CONFIRM:  confirm_need = val[7:0];
            CFG_GIVEUP:   giveup_ms = val;
            CFG_JAMCLEAR: jam_clear_after = val;
            CFG_BACKOFF:  backoff_len = val;
            CFG_HOLD:     hold_idle = val[0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    // block must be idle; writes all eight registers
    task automatic load_settings(input logic [15:0] settle, input logic [15:0] poll,
                                 input logic [15:0] level, input logic [15:0] confirm,
                                 input logic [15:0] giveup, input logic [15:0] jclear,
                                 input logic [15:0] backoff, input logic [15:0] hold);
        write_reg(CFG_SETTLE, settle);
        write_reg(CFG_POLL, poll);
        write_reg(CFG_LEVEL, level);
        write_reg(CFG_CONFIRM, confirm);
        write_reg(CFG_GIVEUP, giveup);
        write_reg(CFG_JAMCLEAR, jclear);
        write_reg(CFG_BACKOFF, backoff);
        write_reg(CFG_HOLD, hold);
        settings_used++;
    endtask

    function automatic t_req make_req(input logic [1:0] mode, input logic slot,
                                      input logic [9:0] load);
        t_req rq;
        rq.mode = mode;
        rq.step_slot = slot;
        rq.load_reading = load;
        return rq;
    endfunction

    // mostly ticks, rare commands; low_bias pushes readings under the stall level
    function automatic t_req random_request(input bit low_bias);
        t_req rq;
        int pick;
        pick = $urandom_range(0, 99);
        rq.step_slot = 1'($urandom_range(0, 1));
        rq.load_reading = 10'($urandom_range(0, 1023));
        if (pick < 3)
            rq.mode = MODE_RUN;
        else if (pick < 5)
            rq.mode = MODE_STOP;
        else if (pick < 6)
            rq.mode = MODE_SPARE;
        else
            rq.mode = MODE_TICK;
        if (low_bias && low_level != 0 && $urandom_range(0, 4) != 0)
            rq.load_reading = 10'($urandom_range(0, low_level - 10'd1));
        return rq;
    endfunction

    // a run command, then random traffic in stretches of heavy and light load
    task automatic queue_random_traffic(input int count);
        bit low_bias;
        int stretch;
        low_bias = 1'b0;
        stretch = 0;
        cmd_queue.push_back(make_req(MODE_RUN, 1'b0, 10'd0));
        for (int n = 1; n < count; n++) begin
            if (stretch == 0) begin
                low_bias = $urandom_range(0, 2) != 0;
                stretch = $urandom_range(3, 30);
            end
            stretch--;
            cmd_queue.push_back(random_request(low_bias));
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: commands, field extremes, ignored mode
        cmd_queue.push_back(make_req(MODE_SPARE, 1'b1, 10'h3FF));
        cmd_queue.push_back(make_req(MODE_STOP, 1'b0, 10'd0));
        cmd_queue.push_back(make_req(MODE_TICK, 1'b1, 10'd0));
        cmd_queue.push_back(make_req(MODE_RUN, 1'b0, 10'd0));
        cmd_queue.push_back(make_req(MODE_TICK, 1'b1, 10'h3FF));
        cmd_queue.push_back(make_req(MODE_TICK, 1'b0, 10'd0));
        cmd_queue.push_back(make_req(MODE_TICK, 1'b1, 10'h155));
        cmd_queue.push_back(make_req(MODE_STOP, 1'b1, 10'h2AA));
        cmd_queue.push_back(make_req(MODE_TICK, 1'b1, 10'd0));
        drain_block(4);

        // zero confirm count and zero back-off, give-up right after the first
        // back-off, stop with the driver held, run while stopped and reversing
        load_settings(16'd1, 16'd0, 16'd512, 16'd0, 16'd0, 16'd2, 16'd0, 16'd1);
        cmd_queue.push_back(make_req(MODE_RUN, 1'b0, 10'd0));
        cmd_queue.push_back(make_req(MODE_TICK, 1'b1, 10'd3));
        cmd_queue.push_back(make_req(MODE_TICK, 1'b1, 10'd900));
        cmd_queue.push_back(make_req(MODE_TICK, 1'b1, 10'd1));
        cmd_queue.push_back(make_req(MODE_TICK, 1'b1, 10'd0));
        cmd_queue.push_back(make_req(MODE_TICK, 1'b0, 10'd0));
        cmd_queue.push_back(make_req(MODE_RUN, 1'b0, 10'd0));
        cmd_queue.push_back(make_req(MODE_TICK, 1'b1, 10'h3FF));
        cmd_queue.push_back(make_req(MODE_TICK, 1'b0, 10'h2AA));
        cmd_queue.push_back(make_req(MODE_TICK, 1'b1, 10'd0));
        cmd_queue.push_back(make_req(MODE_RUN, 1'b0, 10'd0));
        cmd_queue.push_back(make_req(MODE_STOP, 1'b0, 10'd0));
        cmd_queue.push_back(make_req(MODE_TICK, 1'b1, 10'd0));
        drain_block(4);

        // all registers at their lowest, then at their highest
        idle_on = 1'b1;
        load_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        queue_random_traffic(100);
        drain_block(4);
        load_settings(16'hFFFF, 16'hFFFF, 16'h03FF, 16'h00FF,
                      16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1);
        queue_random_traffic(80);
        drain_block(4);

        // small random settings so stalls, back-offs and give-ups come often;
        // the sender halts halfway through each set until all results are back
        for (int p = 0; p < 8; p++) begin
            idle_on = (p % 3) != 0;
            load_settings(16'($urandom_range(0, 20)), 16'($urandom_range(0, 4)),
                          16'($urandom_range(0, 1023)), 16'($urandom_range(0, 4)),
                          16'($urandom_range(0, 80)), 16'($urandom_range(0, 40)),
                          16'($urandom_range(0, 8)), 16'($urandom_range(0, 1)));
            queue_random_traffic(70);
            drain_block(0);
            queue_random_traffic(70);
            drain_block(4);
        end

        drain_block(10);
        $display("sent %0d requests under %0d register settings, %0d results checked",
                 sent_reqs, settings_used, checked_results);
        $display("stalls confirmed %0d, give-ups %0d, backward steps %0d",
                 stalls_due, giveups_due, back_steps_due);
        if (mismatches == 0 && motor_outputs_due.size() == 0) begin
            $display("stall_antijam_sequencer verification clean");
        end else begin
            $display("stall_antijam_sequencer verification failed");
        end
        $finish;
    end

endmodule
